// ===== hdl/pp_pkg.sv =====
`default_nettype none

package pp_pkg;

    localparam int MAX_ACCEPTORS = 16;
    localparam int ADDR_W        = 4;

    localparam logic FUNC_PROPOSE  = 1'b0;
    localparam logic FUNC_RESPONSE = 1'b1;

    localparam logic [1:0] REG_FIRST_NUMBER   = 2'd0;
    localparam logic [1:0] REG_NUMBER_STEP    = 2'd1;
    localparam logic [1:0] REG_ACCEPTOR_COUNT = 2'd2;

    typedef enum logic [1:0] {
        KIND_PREPARE = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_FAILED  = 2'd2
    } kind_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] proposed_value;
        logic               prepare_ok;
        logic               had_accepted;
        logic [31:0]        prior_number;
        logic signed [31:0] prior_value;
    } cmd_t;

    typedef struct packed {
        logic [31:0] first_number;
        logic [31:0] number_step;
        logic [4:0]  acceptor_count;
        logic        load_first;
    } cfg_t;

    // one or more result beats, targets counting up from target_base
    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [3:0]         target_base;
        logic [4:0]         beats;
        logic [31:0]        round_number;
        logic signed [31:0] value;
    } burst_t;

endpackage

`default_nettype wire

// ===== hdl/pp_in_if.sv =====
`default_nettype none

interface pp_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] proposed_value;
    logic               prepare_ok;
    logic               had_accepted;
    logic [31:0]        prior_number;
    logic signed [31:0] prior_value;

    modport source (
        output valid, func, proposed_value, prepare_ok, had_accepted,
               prior_number, prior_value,
        input  ready
    );

    modport sink (
        input  valid, func, proposed_value, prepare_ok, had_accepted,
               prior_number, prior_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/pp_out_if.sv =====
`default_nettype none

interface pp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         message_kind;
    logic [3:0]         target_acceptor;
    logic [31:0]        round_number;
    logic signed [31:0] chosen_value;
    logic               last;

    modport source (
        output valid, message_kind, target_acceptor, round_number, chosen_value, last,
        input  ready
    );

    modport sink (
        input  valid, message_kind, target_acceptor, round_number, chosen_value, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/pp_round.sv =====
`default_nettype none

module pp_round (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire pp_pkg::cmd_t   cmd,
    input  wire pp_pkg::cfg_t   cfg,
    output pp_pkg::burst_t      burst
);
    import pp_pkg::*;

    logic [31:0]        next_number_reg, next_number_next;
    logic [31:0]        active_number_reg, active_number_next;
    logic               busy_reg, busy_next;
    logic [3:0]         answers_seen_reg, answers_seen_next;
    logic               best_valid_reg, best_valid_next;
    logic [31:0]        best_number_reg, best_number_next;
    logic signed [31:0] best_value_reg, best_value_next;
    logic signed [31:0] own_value_reg, own_value_next;

    logic [4:0]         count_sat;
    logic [4:0]         majority;
    logic               best_take;
    logic [3:0]         answers_inc;

    always_comb
    begin
        count_sat = (32'(cfg.acceptor_count) > MAX_ACCEPTORS) ? 5'(MAX_ACCEPTORS)
                                                              : cfg.acceptor_count;
        majority  = {1'b0, count_sat[4:1]} + 5'd1;
    end

    assign best_take   = cmd.had_accepted &&
                         (!best_valid_reg || (cmd.prior_number > best_number_reg));
    assign answers_inc = answers_seen_reg + 4'd1;

    always_comb
    begin
        next_number_next   = next_number_reg;
        active_number_next = active_number_reg;
        busy_next          = busy_reg;
        answers_seen_next  = answers_seen_reg;
        best_valid_next    = best_valid_reg;
        best_number_next   = best_number_reg;
        best_value_next    = best_value_reg;
        own_value_next     = own_value_reg;

        burst.valid        = 1'b0;
        burst.kind         = KIND_PREPARE;
        burst.target_base  = 4'd0;
        burst.beats        = 5'd1;
        burst.round_number = active_number_reg;
        burst.value        = 32'sd0;

        if (take)
        begin
            if (cmd.func == FUNC_PROPOSE)
            begin
                active_number_next = next_number_reg;
                next_number_next   = next_number_reg + cfg.number_step;
                own_value_next     = cmd.proposed_value;
                busy_next          = 1'b1;
                answers_seen_next  = 4'd0;
                best_valid_next    = 1'b0;
                best_number_next   = 32'd0;
                best_value_next    = 32'sd0;
                burst.valid        = 1'b1;
                burst.round_number = next_number_reg;
            end
            else if (busy_reg)
            begin
                burst.valid = 1'b1;
                if (!cmd.prepare_ok)
                begin
                    busy_next         = 1'b0;
                    burst.kind        = KIND_FAILED;
                    burst.target_base = answers_seen_reg;
                end
                else
                begin
                    if (best_take)
                    begin
                        best_valid_next  = 1'b1;
                        best_number_next = cmd.prior_number;
                        best_value_next  = cmd.prior_value;
                    end
                    answers_seen_next = answers_inc;
                    if ({1'b0, answers_inc} < majority)
                    begin
                        burst.target_base = answers_inc;
                    end
                    else
                    begin
                        busy_next   = 1'b0;
                        burst.kind  = KIND_ACCEPT;
                        burst.beats = majority;
                        burst.value = best_take      ? cmd.prior_value :
                                      best_valid_reg ? best_value_reg  : own_value_reg;
                    end
                end
            end
        end
        else if (cfg.load_first)
        begin
            next_number_next = cfg.first_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_number_reg   <= 32'd0;
            active_number_reg <= 32'd0;
            busy_reg          <= 1'b0;
            answers_seen_reg  <= 4'd0;
            best_valid_reg    <= 1'b0;
            best_number_reg   <= 32'd0;
            best_value_reg    <= 32'sd0;
            own_value_reg     <= 32'sd0;
        end
        else
        begin
            next_number_reg   <= next_number_next;
            active_number_reg <= active_number_next;
            busy_reg          <= busy_next;
            answers_seen_reg  <= answers_seen_next;
            best_valid_reg    <= best_valid_next;
            best_number_reg   <= best_number_next;
            best_value_reg    <= best_value_next;
            own_value_reg     <= own_value_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/paxos_proposer.sv =====
// Channel  Dir  Beat
// cmd      in   propose (func 0) or prepare response (func 1)
// msg      out  prepare request, accept request or round failure
// apb      cfg  first_number @0x0, number_step @0x4, acceptor_count @0x8
//
// One cmd beat per cycle; the round update is done in the accepting cycle.
// Each cmd beat yields zero or one msg beat, except the accept burst, which
// yields majority beats from the output register's beat counter, one per cycle
// while msg is ready; cmd is held off until the last beat of a burst leaves.
// rst_n is asynchronous; no start-up sweep, cmd ready from the first edge after release.
// A stalled msg keeps cmd ready low only once the output register is full.
`default_nettype none

module paxos_proposer (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [pp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    pp_in_if.sink                       cmd,
    pp_out_if.source                    msg
);
    import pp_pkg::*;

    logic [31:0]        first_number_reg;
    logic [31:0]        number_step_reg;
    logic [4:0]         acceptor_count_reg;
    logic               cfg_wr;
    logic [1:0]         reg_sel;

    cmd_t               cmd_beat;
    cfg_t               cfg;
    burst_t             burst;
    logic               take;

    logic               out_valid_reg;
    logic [4:0]         idx_reg;
    logic [4:0]         beats_reg;
    logic [3:0]         base_reg;
    kind_t              kind_reg;
    logic [31:0]        round_reg;
    logic signed [31:0] value_reg;
    logic               out_last;
    logic               out_fire;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_number_reg   <= 32'd0;
            number_step_reg    <= 32'd1;
            acceptor_count_reg <= 5'd3;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_FIRST_NUMBER:   first_number_reg   <= pwdata;
                REG_NUMBER_STEP:    number_step_reg    <= pwdata;
                REG_ACCEPTOR_COUNT: acceptor_count_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FIRST_NUMBER:   prdata = first_number_reg;
            REG_NUMBER_STEP:    prdata = number_step_reg;
            REG_ACCEPTOR_COUNT: prdata = {27'd0, acceptor_count_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.first_number   = pwdata;
    assign cfg.number_step    = number_step_reg;
    assign cfg.acceptor_count = acceptor_count_reg;
    assign cfg.load_first     = cfg_wr && (reg_sel == REG_FIRST_NUMBER);

    assign cmd_beat.func           = cmd.func;
    assign cmd_beat.proposed_value = cmd.proposed_value;
    assign cmd_beat.prepare_ok     = cmd.prepare_ok;
    assign cmd_beat.had_accepted   = cmd.had_accepted;
    assign cmd_beat.prior_number   = cmd.prior_number;
    assign cmd_beat.prior_value    = cmd.prior_value;

    assign out_last  = (idx_reg + 5'd1) == beats_reg;
    assign out_fire  = out_valid_reg && msg.ready;
    assign cmd.ready = !out_valid_reg || (msg.ready && out_last);
    assign take      = cmd.valid && cmd.ready;

    pp_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .cmd   (cmd_beat),
        .cfg   (cfg),
        .burst (burst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 5'd0;
        end
        else if (take && burst.valid)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= 5'd0;
        end
        else if (out_fire)
        begin
            if (out_last)
                out_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && burst.valid)
        begin
            beats_reg <= burst.beats;
            base_reg  <= burst.target_base;
            kind_reg  <= burst.kind;
            round_reg <= burst.round_number;
            value_reg <= burst.value;
        end
    end

    assign msg.valid           = out_valid_reg;
    assign msg.message_kind    = kind_reg;
    assign msg.target_acceptor = base_reg + idx_reg[3:0];
    assign msg.round_number    = round_reg;
    assign msg.chosen_value    = value_reg;
    assign msg.last            = out_last;

endmodule

`default_nettype wire

// ===== hdl/pp_checker.sv =====
`default_nettype none

module pp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_ready,
    input wire logic        msg_valid,
    input wire logic        msg_ready,
    input wire logic [1:0]  msg_kind,
    input wire logic [3:0]  msg_target,
    input wire logic [31:0] msg_round,
    input wire logic        msg_last
);
    import pp_pkg::*;

    // stalled beat stays
    a_msg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> msg_valid)
        else $error("msg beat dropped while stalled");

    // only accept requests come in multi-beat bursts
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && (msg_kind != KIND_ACCEPT) |-> msg_last)
        else $error("non-accept beat not marked last");

    // burst continues to the next acceptor in the same round
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && !msg_last |=>
            msg_valid && (msg_kind == KIND_ACCEPT) &&
            (msg_target == $past(msg_target) + 4'd1) && (msg_round == $past(msg_round)))
        else $error("accept burst broken");

    // cmd only held off by a pending beat that does not finish now
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> msg_valid && !(msg_ready && msg_last))
        else $error("cmd stalled without pending output");

endmodule

bind paxos_proposer pp_checker u_pp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd.ready),
    .msg_valid  (msg.valid),
    .msg_ready  (msg.ready),
    .msg_kind   (msg.message_kind),
    .msg_target (msg.target_acceptor),
    .msg_round  (msg.round_number),
    .msg_last   (msg.last)
);

`default_nettype wire

// ===== sim/paxos_round_checker.sv =====
`default_nettype none

module paxos_round_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic                      pready,
    input  wire logic [pp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    pp_in_if                               cmd,
    pp_out_if                              msg,
    output int unsigned                    msgs_due,
    output int unsigned                    msgs_checked,
    output int unsigned                    bad_fields
);
    timeunit 1ns;
    timeprecision 1ps;

    import pp_pkg::*;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         target;
        logic [31:0]        round;
        logic signed [31:0] value;
        logic               last;
    } msg_beat_t;

    msg_beat_t due_q[$];

    logic [31:0]        cfg_step;
    logic [4:0]         cfg_count;

    logic [31:0]        next_round;
    logic [31:0]        round_no;
    logic               in_round;
    logic [3:0]         replies;
    logic               have_prior;
    logic [31:0]        prior_best_no;
    logic signed [31:0] prior_best_val;
    logic signed [31:0] own_val;

    int unsigned        n_checked;
    int unsigned        n_bad;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        n_bad++;
        $display("%0t ns: msg %s got %h, want %h", $time, field, got, want);
    endtask

    task automatic check_beat();
        msg_beat_t want;
        n_checked++;
        if (due_q.size() == 0)
        begin
            report_mismatch("beat with none due", msg.round_number, 32'd0);
            return;
        end
        want = due_q.pop_front();
        if (msg.message_kind !== want.kind)
            report_mismatch("message_kind", 32'(msg.message_kind), 32'(want.kind));
        if (msg.target_acceptor !== want.target)
            report_mismatch("target_acceptor", 32'(msg.target_acceptor), 32'(want.target));
        if (msg.round_number !== want.round)
            report_mismatch("round_number", msg.round_number, want.round);
        if (msg.chosen_value !== want.value)
            report_mismatch("chosen_value", msg.chosen_value, want.value);
        if (msg.last !== want.last)
            report_mismatch("last", 32'(msg.last), 32'(want.last));
    endtask

    task automatic take_write();
        case (paddr[ADDR_W-1:2])
            REG_FIRST_NUMBER:   next_round = pwdata;
            REG_NUMBER_STEP:    cfg_step   = pwdata;
            REG_ACCEPTOR_COUNT: cfg_count  = pwdata[4:0];
            default: ;
        endcase
    endtask

    task automatic advance_round();
        logic [4:0]         capped;
        logic [4:0]         quorum;
        logic signed [31:0] carry;
        if (cmd.func == FUNC_PROPOSE)
        begin
            round_no       = next_round;
            next_round     = next_round + cfg_step;
            own_val        = cmd.proposed_value;
            in_round       = 1'b1;
            replies        = 4'd0;
            have_prior     = 1'b0;
            prior_best_no  = 32'd0;
            prior_best_val = 32'sd0;
            due_q.push_back(msg_beat_t'{KIND_PREPARE, 4'd0, round_no, 32'sd0, 1'b1});
        end
        else if (in_round)
        begin
            if (!cmd.prepare_ok)
            begin
                in_round = 1'b0;
                due_q.push_back(msg_beat_t'{KIND_FAILED, replies, round_no, 32'sd0, 1'b1});
            end
            else
            begin
                // ties keep the proposal already held
                if (cmd.had_accepted && (!have_prior || cmd.prior_number > prior_best_no))
                begin
                    have_prior     = 1'b1;
                    prior_best_no  = cmd.prior_number;
                    prior_best_val = cmd.prior_value;
                end
                replies = replies + 4'd1;
                capped  = (cfg_count > 5'(MAX_ACCEPTORS)) ? 5'(MAX_ACCEPTORS) : cfg_count;
                quorum  = capped / 5'd2 + 5'd1;
                if ({1'b0, replies} < quorum)
                    due_q.push_back(msg_beat_t'{KIND_PREPARE, replies, round_no, 32'sd0, 1'b1});
                else
                begin
                    in_round = 1'b0;
                    carry    = have_prior ? prior_best_val : own_val;
                    for (int i = 0; i < quorum; i++)
                        due_q.push_back(msg_beat_t'{KIND_ACCEPT, 4'(i), round_no, carry,
                                                    (i + 1 == quorum)});
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_step       = 32'd1;
            cfg_count      = 5'd3;
            next_round     = 32'd0;
            round_no       = 32'd0;
            in_round       = 1'b0;
            replies        = 4'd0;
            have_prior     = 1'b0;
            prior_best_no  = 32'd0;
            prior_best_val = 32'sd0;
            own_val        = 32'sd0;
            due_q.delete();
            msgs_due       <= 0;
            msgs_checked   <= 0;
            bad_fields     <= 0;
        end
        else
        begin
            // outputs first: a beat can never stem from a cmd beat of the same edge
            if (msg.valid && msg.ready)
                check_beat();
            if (psel && penable && pwrite && pready)
                take_write();
            if (cmd.valid && cmd.ready)
                advance_round();
            msgs_due     <= due_q.size();
            msgs_checked <= n_checked;
            bad_fields   <= n_bad;
        end
    end

    initial
    begin
        n_checked = 0;
        n_bad     = 0;
    end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 46;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    pp_in_if  cmd ();
    pp_out_if msg ();

    int unsigned msgs_due;
    int unsigned msgs_checked;
    int unsigned bad_fields;

    bit          source_gaps;
    bit          sink_stalls;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          cur_count;
    int          items;
    int          rounds;
    int          settings_used;

    paxos_proposer u_top (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .cmd,
        .msg
    );

    paxos_round_checker u_check (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .pready,
        .paddr,
        .pwdata,
        .cmd,
        .msg,
        .msgs_due,
        .msgs_checked,
        .bad_fields
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!source_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // narrow prior numbers so that ties and reorderings turn up
    function automatic logic [31:0] prior_no();
        if ($urandom_range(0, 1))
            return $urandom_range(0, 7);
        return pick32();
    endfunction

    function automatic int quorum_of(input int count);
        return ((count > MAX_ACCEPTORS) ? MAX_ACCEPTORS : count) / 2 + 1;
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            msg.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (sink_stalls && $urandom_range(0, 99) < 25)
        begin
            msg.ready  <= 1'b0;
            stall_left <= stall_len() - 1;
        end
        else
            msg.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (msg.valid && msg.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (idx == REG_ACCEPTOR_COUNT)
            cur_count = int'(data[4:0]);
    endtask

    task automatic program_regs(input logic [31:0] first, input logic [31:0] step,
                                input logic [4:0] count);
        write_reg(REG_FIRST_NUMBER, first);
        write_reg(REG_NUMBER_STEP, step);
        write_reg(REG_ACCEPTOR_COUNT, 32'(count));
        settings_used++;
    endtask

    task automatic send(input logic func, input logic [31:0] pv, input logic ok,
                        input logic had, input logic [31:0] pn, input logic [31:0] pval);
        int n;
        cmd.func           <= func;
        cmd.proposed_value <= pv;
        cmd.prepare_ok     <= ok;
        cmd.had_accepted   <= had;
        cmd.prior_number   <= pn;
        cmd.prior_value    <= pval;
        cmd.valid          <= 1'b1;
        do @(posedge clk); while (!cmd.ready);
        n = gap_len();
        if (n > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic propose(input logic [31:0] value);
        send(FUNC_PROPOSE, value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             $urandom, $urandom);
    endtask

    task automatic respond(input logic ok, input logic had, input logic [31:0] pn,
                           input logic [31:0] pval);
        send(FUNC_RESPONSE, $urandom, ok, had, pn, pval);
    endtask

    // wait for every due beat, then for any ignored beat still in flight
    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (msgs_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_round();
        int  quorum;
        bit  ok;
        quorum = quorum_of(cur_count);
        rounds++;
        propose(pick32());
        items++;
        for (int i = 0; i < quorum; i++)
        begin
            if ($urandom_range(0, 99) < 4)
                return;
            ok = ($urandom_range(0, 99) < 88);
            respond(ok, 1'($urandom_range(0, 1)), prior_no(), pick32());
            items++;
            if (!ok)
                return;
        end
    endtask

    initial
    begin
        int r;
        int goal;
        rst_n              = 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cmd.valid         <= 1'b0;
        cmd.func          <= FUNC_PROPOSE;
        cmd.proposed_value <= '0;
        cmd.prepare_ok    <= 1'b0;
        cmd.had_accepted  <= 1'b0;
        cmd.prior_number  <= '0;
        cmd.prior_value   <= '0;
        cur_count          = 3;
        items              = 0;
        rounds             = 0;
        settings_used      = 1;
        source_gaps        = 1'b0;
        sink_stalls        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: three acceptors, quorum of two
        respond(1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
        propose(32'h7fff_ffff);
        respond(1'b1, 1'b1, 32'hffff_ffff, 32'h8000_0000);
        respond(1'b1, 1'b1, 32'hffff_ffff, 32'd5);
        propose(32'hffff_ffff);
        respond(1'b1, 1'b0, 32'd0, 32'd0);
        respond(1'b1, 1'b1, 32'd0, 32'd7);
        propose(32'd0);
        respond(1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
        propose(32'd1);
        respond(1'b1, 1'b0, 32'd3, 32'd3);
        propose(32'd2);
        respond(1'b0, 1'b0, 32'd0, 32'd0);
        drain();

        source_gaps = 1'b1;
        sink_stalls = 1'b1;
        program_regs(32'hffff_ffff, 32'hffff_ffff, 5'd0);
        propose(32'h8000_0000);
        respond(1'b1, 1'b1, 32'd5, 32'd9);
        drain();

        program_regs(32'h8000_0000, 32'h7fff_ffff, 5'd31);
        propose(32'h1234_5678);
        for (int i = 0; i < 9; i++)
            respond(1'b1, i[0], 32'(i * 7 % 5), 32'(i + 100));
        propose(32'h0bad_cafe);
        respond(1'b1, 1'b0, 32'd0, 32'd0);
        respond(1'b1, 1'b1, 32'h0000_0010, 32'h7fff_ffff);
        drain();
        // quorum shrinks below the replies already held
        write_reg(REG_ACCEPTOR_COUNT, 32'd1);
        respond(1'b1, 1'b0, 32'd0, 32'd0);
        drain();
        items = 29;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            source_gaps = (ph != 2);
            sink_stalls = (ph != 2 && ph != 5);
            if (ph == 0)
                program_regs(32'd0, 32'd0, 5'd1);
            else if (ph == 1)
                program_regs(32'hffff_ffff, 32'd1, 5'd16);
            else
            begin
                r = $urandom_range(0, 99);
                program_regs(pick32(), ($urandom_range(0, 1) ? pick32() : $urandom_range(0, 3)),
                             (r < 60) ? 5'($urandom_range(1, 5)) :
                             (r < 75) ? 5'd0 :
                             (r < 90) ? 5'($urandom_range(6, 16)) :
                                        5'($urandom_range(17, 31)));
            end
            goal = items + PHASE_ITEMS;
            while (items < goal)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                begin
                    respond(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick32(),
                            pick32());
                    items++;
                end
                else if (r < 8)
                    drain();
                else
                    run_round();
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d command beats in %0d rounds over %0d register settings",
                 items, rounds, settings_used);
        $display("%0d message beats checked, %0d field mismatches", msgs_checked, bad_fields);
        if (bad_fields == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
